// ===== sv/tbvt_pkg.sv =====
// shared types and constants for the tagged binary value tokenizer
// no dependencies; imported by the stack memory, the parser and the top level
package tbvt_pkg;

    localparam int MAX_DEPTH = 16;
    localparam int IDX_W     = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int OPEN_W    = $clog2(MAX_DEPTH + 1);
    localparam int LIM_W     = (OPEN_W > 5) ? OPEN_W : 5;
    localparam int REM_W     = 6;

    localparam logic [4:0] DEPTH_LIMIT_RST = 5'd16;

    // single byte tags
    localparam logic [7:0] TAG_NULL  = 8'h60;
    localparam logic [7:0] TAG_TRUE  = 8'h61;
    localparam logic [7:0] TAG_FALSE = 8'h62;
    localparam logic [7:0] TAG_FLOAT = 8'h63;
    localparam logic [7:0] TAG_S64   = 8'h64;
    localparam logic [7:0] TAG_U64   = 8'h65;
    localparam logic [7:0] TAG_LSTR  = 8'h66;
    localparam logic [7:0] TAG_S32   = 8'h67;
    localparam logic [7:0] TAG_U32   = 8'h68;

    // tag classes, top three bits
    localparam logic [2:0] CLS_SSTR = 3'b100;
    localparam logic [2:0] CLS_TINY = 3'b110;
    localparam logic [2:0] CLS_LIST = 3'b010;
    localparam logic [2:0] CLS_DICT = 3'b001;

    // token kinds
    localparam logic [3:0] TK_NULL     = 4'd0;
    localparam logic [3:0] TK_TRUE     = 4'd1;
    localparam logic [3:0] TK_FALSE    = 4'd2;
    localparam logic [3:0] TK_INT      = 4'd3;
    localparam logic [3:0] TK_FLOAT    = 4'd4;
    localparam logic [3:0] TK_STR_HDR  = 4'd5;
    localparam logic [3:0] TK_STR_BYTE = 4'd6;
    localparam logic [3:0] TK_LIST     = 4'd7;
    localparam logic [3:0] TK_DICT     = 4'd8;
    localparam logic [3:0] TK_BAD_TAG  = 4'd9;
    localparam logic [3:0] TK_TOO_DEEP = 4'd10;

    typedef struct packed {
        logic [3:0]  token_kind;
        logic [63:0] token_value;
        logic        is_signed;
        logic [4:0]  nest_depth;
        logic [4:0]  closes;
        logic        value_done;
    } token_t;

    typedef struct packed {
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [REM_W-1:0] wr_data;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
    } stack_req_t;

endpackage

// ===== sv/tbvt_byte_if.sv =====
// input byte channel of the tokenizer
// depends on nothing
interface tbvt_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== sv/tbvt_token_if.sv =====
// token output channel of the tokenizer
// depends on nothing
interface tbvt_token_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic        is_signed;
    logic [4:0]  nest_depth;
    logic [4:0]  closes;
    logic        value_done;

    modport source (output valid, output token_kind, output token_value, output is_signed,
                    output nest_depth, output closes, output value_done, input ready);
    modport sink   (input valid, input token_kind, input token_value, input is_signed,
                    input nest_depth, input closes, input value_done, output ready);
endinterface

// ===== sv/tbvt_cfg_if.sv =====
// configuration write channel carrying the depth limit
// depends on nothing
interface tbvt_cfg_if;
    logic       valid;
    logic       ready;
    logic [4:0] depth_limit;

    modport source (output valid, output depth_limit, input ready);
    modport sink   (input valid, input depth_limit, output ready);
endinterface

// ===== sv/tbvt_stack_mem.sv =====
// container stack: elements left per open level, one write and one read port
// uses tbvt_pkg; read data is registered
module tbvt_stack_mem
    import tbvt_pkg::*;
(
    input  logic             clk,
    input  stack_req_t       req,
    output logic [REM_W-1:0] rd_data
);

    logic [REM_W-1:0] mem [MAX_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data <= mem[req.rd_addr];
        end
    end

endmodule

// ===== sv/tbvt_parser.sv =====
// byte decoder and control sequencer of the tokenizer
// uses tbvt_pkg and tbvt_byte_if; drives the stack memory through stack_req_t
module tbvt_parser
    import tbvt_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [4:0]       depth_limit,
    tbvt_byte_if.sink        stream,
    output stack_req_t       stk_req,
    input  logic [REM_W-1:0] stk_rd_data,
    output logic             res_valid,
    input  logic             res_ready,
    output token_t           res
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    localparam logic [1:0] PH_TAG   = 2'd0;
    localparam logic [1:0] PH_FIELD = 2'd1;
    localparam logic [1:0] PH_STR   = 2'd2;
    localparam logic [1:0] PH_ERR   = 2'd3;

    localparam logic [2:0] PK_NONE  = 3'd0;
    localparam logic [2:0] PK_FLOAT = 3'd1;
    localparam logic [2:0] PK_S64   = 3'd2;
    localparam logic [2:0] PK_U64   = 3'd3;
    localparam logic [2:0] PK_S32   = 3'd4;
    localparam logic [2:0] PK_U32   = 3'd5;
    localparam logic [2:0] PK_LEN   = 3'd6;

    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_DEPTH);

    logic [1:0]        state_reg, state_next;
    logic [1:0]        phase_reg, phase_next;
    logic [OPEN_W-1:0] open_reg, open_next;
    logic [3:0]        bytes_left_reg, bytes_left_next;
    logic [63:0]       asm_reg, asm_next;
    logic [31:0]       str_left_reg, str_left_next;
    logic [2:0]        pk_reg, pk_next;
    token_t            res_reg, res_next;

    logic              accept;
    logic              fs;
    logic [7:0]        b;
    logic [1:0]        phase_eff;
    logic [OPEN_W-1:0] open_eff;
    logic [3:0]        bl_eff, bl_new, total, idx;
    logic [63:0]       asm_eff, asm_new;
    logic [31:0]       sl_eff, sl_new, len;
    logic [2:0]        pk_eff;
    logic [REM_W-1:0]  count;
    logic [LIM_W-1:0]  lim, dl_ext, open_ext;
    logic              do_emit, do_complete, do_string;
    logic [OPEN_W-1:0] open_pop;

    assign accept    = stream.valid && stream.ready;
    assign stream.ready = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_EMIT);
    assign res       = res_reg;

    assign fs        = stream.frame_start;
    assign b         = stream.data_byte;
    assign phase_eff = fs ? PH_TAG : phase_reg;
    assign open_eff  = fs ? '0 : open_reg;
    assign bl_eff    = fs ? 4'd0 : bytes_left_reg;
    assign asm_eff   = fs ? 64'd0 : asm_reg;
    assign sl_eff    = fs ? 32'd0 : str_left_reg;
    assign pk_eff    = fs ? PK_NONE : pk_reg;

    assign dl_ext   = LIM_W'(depth_limit);
    assign lim      = (dl_ext > MAX_LIM) ? MAX_LIM : dl_ext;
    assign open_ext = LIM_W'(open_eff);
    assign open_pop = open_reg - 1'b1;

    // field byte assembly, little-endian
    assign total   = (pk_eff == PK_S32 || pk_eff == PK_U32 || pk_eff == PK_LEN) ? 4'd4 : 4'd8;
    assign idx     = (bl_eff <= total) ? total - bl_eff : 4'd0;
    assign asm_new = asm_eff | ({56'd0, b} << {idx[2:0], 3'b000});
    assign bl_new  = (bl_eff == 4'd0) ? 4'd0 : bl_eff - 4'd1;
    assign sl_new  = (sl_eff == 32'd0) ? 32'd0 : sl_eff - 32'd1;

    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        open_next       = open_reg;
        bytes_left_next = bytes_left_reg;
        asm_next        = asm_reg;
        str_left_next   = str_left_reg;
        pk_next         = pk_reg;
        res_next        = res_reg;
        stk_req         = '0;
        do_emit         = 1'b0;
        do_complete     = 1'b0;
        do_string       = 1'b0;
        len             = 32'd0;
        count           = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    phase_next      = phase_eff;
                    open_next       = open_eff;
                    bytes_left_next = bl_eff;
                    asm_next        = asm_eff;
                    str_left_next   = sl_eff;
                    pk_next         = pk_eff;
                    res_next.token_kind  = TK_NULL;
                    res_next.token_value = 64'd0;
                    res_next.is_signed   = 1'b0;
                    res_next.nest_depth  = 5'(open_eff);
                    res_next.closes      = 5'd0;
                    res_next.value_done  = 1'b0;

                    case (phase_eff)
                        PH_FIELD:
                        begin
                            asm_next        = asm_new;
                            bytes_left_next = bl_new;
                            if (bl_new == 4'd0)
                            begin
                                phase_next  = PH_TAG;
                                do_complete = 1'b1;
                                res_next.token_kind = TK_INT;
                                case (pk_eff)
                                    PK_FLOAT:
                                    begin
                                        res_next.token_kind  = TK_FLOAT;
                                        res_next.token_value = asm_new;
                                    end
                                    PK_S64:
                                    begin
                                        res_next.token_value = asm_new;
                                        res_next.is_signed   = 1'b1;
                                    end
                                    PK_U64:
                                    begin
                                        res_next.token_value = asm_new;
                                    end
                                    PK_S32:
                                    begin
                                        res_next.token_value = {{32{asm_new[31]}}, asm_new[31:0]};
                                        res_next.is_signed   = 1'b1;
                                    end
                                    PK_U32:
                                    begin
                                        res_next.token_value = {32'd0, asm_new[31:0]};
                                    end
                                    default:
                                    begin
                                        do_complete = 1'b0;
                                        do_string   = 1'b1;
                                        len         = asm_new[31:0];
                                    end
                                endcase
                            end
                        end
                        PH_STR:
                        begin
                            str_left_next        = sl_new;
                            res_next.token_kind  = TK_STR_BYTE;
                            res_next.token_value = {56'd0, b};
                            if (sl_new != 32'd0)
                            begin
                                do_emit = 1'b1;
                            end
                            else
                            begin
                                phase_next  = PH_TAG;
                                do_complete = 1'b1;
                            end
                        end
                        PH_TAG:
                        begin
                            case (b) inside
                                TAG_NULL, TAG_TRUE, TAG_FALSE:
                                begin
                                    do_complete = 1'b1;
                                    res_next.token_kind = (b == TAG_NULL) ? TK_NULL :
                                                          (b == TAG_TRUE) ? TK_TRUE : TK_FALSE;
                                end
                                TAG_FLOAT, TAG_S64, TAG_U64, TAG_LSTR, TAG_S32, TAG_U32:
                                begin
                                    phase_next = PH_FIELD;
                                    asm_next   = 64'd0;
                                    case (b)
                                        TAG_FLOAT: pk_next = PK_FLOAT;
                                        TAG_S64:   pk_next = PK_S64;
                                        TAG_U64:   pk_next = PK_U64;
                                        TAG_LSTR:  pk_next = PK_LEN;
                                        TAG_S32:   pk_next = PK_S32;
                                        default:   pk_next = PK_U32;
                                    endcase
                                    bytes_left_next = (b == TAG_FLOAT || b == TAG_S64 ||
                                                       b == TAG_U64) ? 4'd8 : 4'd4;
                                end
                                default:
                                begin
                                    case (b[7:5]) inside
                                        CLS_SSTR:
                                        begin
                                            do_string = 1'b1;
                                            len       = {27'd0, b[4:0]};
                                        end
                                        CLS_TINY:
                                        begin
                                            do_complete          = 1'b1;
                                            res_next.token_kind  = TK_INT;
                                            res_next.token_value = {59'd0, b[4:0]};
                                        end
                                        CLS_LIST, CLS_DICT:
                                        begin
                                            count = (b[7:5] == CLS_LIST) ? {1'b0, b[4:0]}
                                                                         : {b[4:0], 1'b0};
                                            res_next.token_kind  = (b[7:5] == CLS_LIST) ?
                                                                   TK_LIST : TK_DICT;
                                            res_next.token_value = {59'd0, b[4:0]};
                                            if (count == '0)
                                            begin
                                                // empty container closes itself at once
                                                res_next.closes = 5'd1;
                                                do_complete     = 1'b1;
                                            end
                                            else if (open_ext >= lim)
                                            begin
                                                phase_next          = PH_ERR;
                                                res_next.token_kind = TK_TOO_DEEP;
                                                do_emit             = 1'b1;
                                            end
                                            else
                                            begin
                                                stk_req.wr_en   = 1'b1;
                                                stk_req.wr_addr = open_eff[IDX_W-1:0];
                                                stk_req.wr_data = count;
                                                open_next       = open_eff + 1'b1;
                                                do_emit         = 1'b1;
                                            end
                                        end
                                        default:
                                        begin
                                            phase_next           = PH_ERR;
                                            res_next.token_kind  = TK_BAD_TAG;
                                            res_next.token_value = {56'd0, b};
                                            do_emit              = 1'b1;
                                        end
                                    endcase
                                end
                            endcase
                        end
                        default:
                        begin
                        end
                    endcase

                    if (do_string)
                    begin
                        res_next.token_kind  = TK_STR_HDR;
                        res_next.token_value = {32'd0, len};
                        if (len == 32'd0)
                        begin
                            phase_next  = PH_TAG;
                            do_complete = 1'b1;
                        end
                        else
                        begin
                            str_left_next = len;
                            phase_next    = PH_STR;
                            do_emit       = 1'b1;
                        end
                    end

                    if (do_emit)
                    begin
                        state_next = S_EMIT;
                    end
                    else if (do_complete)
                    begin
                        if (open_eff == '0)
                        begin
                            res_next.value_done = 1'b1;
                            state_next          = S_EMIT;
                        end
                        else
                        begin
                            stk_req.rd_en   = 1'b1;
                            stk_req.rd_addr = IDX_W'(open_eff - 1'b1);
                            state_next      = S_POP;
                        end
                    end
                end
            end
            S_POP:
            begin
                // top entry is in stk_rd_data; pop while it is on its last element
                if (stk_rd_data <= REM_W'(1))
                begin
                    open_next       = open_pop;
                    res_next.closes = res_reg.closes + 5'd1;
                    if (open_pop == '0)
                    begin
                        res_next.value_done = 1'b1;
                        state_next          = S_EMIT;
                    end
                    else
                    begin
                        stk_req.rd_en   = 1'b1;
                        stk_req.rd_addr = IDX_W'(open_pop - 1'b1);
                    end
                end
                else
                begin
                    stk_req.wr_en   = 1'b1;
                    stk_req.wr_addr = IDX_W'(open_pop);
                    stk_req.wr_data = stk_rd_data - REM_W'(1);
                    state_next      = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            phase_reg      <= PH_TAG;
            open_reg       <= '0;
            bytes_left_reg <= 4'd0;
            asm_reg        <= 64'd0;
            str_left_reg   <= 32'd0;
            pk_reg         <= PK_NONE;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            open_reg       <= open_next;
            bytes_left_reg <= bytes_left_next;
            asm_reg        <= asm_next;
            str_left_reg   <= str_left_next;
            pk_reg         <= pk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule

// ===== sv/tagged_binary_value_tokenizer.sv =====
// Tokenizer for a compact tagged binary stream: one byte per input transfer, at most one
// token per byte. A byte is taken in S_IDLE; a byte that yields a token then waits in
// S_EMIT until the output register takes it, and no new byte is taken until then. A
// token that completes elements first passes through S_POP, reading the container stack
// memory: one read, plus one more for every container it closes except the outermost one
// of a finished top level value. Bytes that only collect field data yield no token and
// leave the parser in S_IDLE. The output register lets the next byte be taken while a
// token waits to be transferred. After an error, bytes are dropped until frame_start.
module tagged_binary_value_tokenizer
    import tbvt_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    tbvt_byte_if.sink      stream,
    tbvt_token_if.source   tokens,
    tbvt_cfg_if.sink       cfg
);

    logic [4:0]       depth_limit_reg;
    logic             out_valid_reg, out_valid_next;
    token_t           out_reg;
    stack_req_t       stk_req;
    logic [REM_W-1:0] stk_rd_data;
    logic             res_valid;
    logic             res_ready;
    token_t           res;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_limit_reg <= DEPTH_LIMIT_RST;
        end
        else if (cfg.valid)
        begin
            depth_limit_reg <= cfg.depth_limit;
        end
    end

    tbvt_stack_mem u_stack (
        .clk     (clk),
        .req     (stk_req),
        .rd_data (stk_rd_data)
    );

    tbvt_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .depth_limit (depth_limit_reg),
        .stream      (stream),
        .stk_req     (stk_req),
        .stk_rd_data (stk_rd_data),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // output slot frees when empty or being transferred
    assign res_ready = !out_valid_reg || tokens.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_valid && res_ready)
        begin
            out_valid_next = 1'b1;
        end
        else if (tokens.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign tokens.valid       = out_valid_reg;
    assign tokens.token_kind  = out_reg.token_kind;
    assign tokens.token_value = out_reg.token_value;
    assign tokens.is_signed   = out_reg.is_signed;
    assign tokens.nest_depth  = out_reg.nest_depth;
    assign tokens.closes      = out_reg.closes;
    assign tokens.value_done  = out_reg.value_done;

endmodule
